/* design/alle_pkg.sv */
`timescale 1ns / 1ps
package alle_pkg;

  // node store geometry
  localparam int NODES      = 256;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(NODES);
  localparam int PTR_W      = IDX_W + 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [VALUE_BITS-1:0] val_t;

  // null link
  localparam ptr_t NIL = PTR_W'(NODES);

  // command kind codes on the input word
  localparam logic [2:0] KIND_INS_HEAD  = 3'd0;
  localparam logic [2:0] KIND_INS_TAIL  = 3'd1;
  localparam logic [2:0] KIND_INS_AFTER = 3'd2;
  localparam logic [2:0] KIND_DEL_HEAD  = 3'd3;
  localparam logic [2:0] KIND_DEL_TAIL  = 3'd4;
  localparam logic [2:0] KIND_DEL_AFTER = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    OP_INS_HEAD,
    OP_INS_TAIL,
    OP_INS_AFTER,
    OP_DEL_HEAD,
    OP_DEL_TAIL,
    OP_DEL_AFTER,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t  op;
    val_t item;
    val_t key;
  } cmd_t;

endpackage

/* design/alle_front.sv */
`timescale 1ns / 1ps
module alle_front
  import alle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_item,
  input  logic [31:0] in_match_value,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  cmd_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              wr, rd;
  cmd_t              dec;

  // classify the incoming word
  always_comb begin
    dec.item = val_t'(in_item);
    dec.key  = val_t'(in_match_value);
    unique case (in_kind)
      KIND_INS_HEAD:  dec.op = OP_INS_HEAD;
      KIND_INS_TAIL:  dec.op = OP_INS_TAIL;
      KIND_INS_AFTER: dec.op = OP_INS_AFTER;
      KIND_DEL_HEAD:  dec.op = OP_DEL_HEAD;
      KIND_DEL_TAIL:  dec.op = OP_DEL_TAIL;
      KIND_DEL_AFTER: dec.op = OP_DEL_AFTER;
      default:        dec.op = OP_BAD;
    endcase
  end

  // command queue
  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = ent_r[rp_r];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_comb begin
    wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_r[wp_r] <= dec;
    end
  end

endmodule

/* design/alle_back.sv */
`timescale 1ns / 1ps
module alle_back
  import alle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_status,
  output logic [7:0] out_slot
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FETCH   = 8'b0000_0010,
    S_ALLOC   = 8'b0000_0100,
    S_SEARCH  = 8'b0000_1000,
    S_LAST    = 8'b0001_0000,
    S_UNLINK  = 8'b0010_0000,
    S_RELEASE = 8'b0100_0000,
    S_LINK    = 8'b1000_0000
  } state_t;

  state_t st_r, st_nxt, ret_r, ret_nxt;
  op_t    op_r, op_nxt;
  val_t   item_r, item_nxt, key_r, key_nxt;
  ptr_t   cur_r, cur_nxt, prev_r, prev_nxt, q_r, q_nxt, nq_r, nq_nxt, p_r, p_nxt;
  ptr_t   head_r, head_nxt, free_r, free_nxt;
  logic   ov_r, ov_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic [7:0] oslot_r, oslot_nxt;

  // node stores
  ptr_t   lk_mem [NODES];
  val_t   vs_mem [NODES];
  logic [NODES-1:0] vld_r;
  ptr_t   lk_rd_r;
  val_t   vs_rd_r;
  logic   lv_rd_r;
  idx_t   ra_rd_r;
  ptr_t   link_eff;
  logic   lk_we, vs_we;
  idx_t   lk_wa, vs_wa;
  ptr_t   lk_wd;

  // link of the fetched node, reset chain where never written
  assign link_eff = lv_rd_r ? lk_rd_r : ({1'b0, ra_rd_r} + PTR_W'(1));

  assign empty      = !ov_r;
  assign out_status = ost_r;
  assign out_slot   = oslot_r;
  assign cmd_take   = (st_r == S_IDLE) && !ov_r;

  // command sequencer
  always_comb begin
    st_nxt    = st_r;
    ret_nxt   = ret_r;
    op_nxt    = op_r;
    item_nxt  = item_r;
    key_nxt   = key_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    q_nxt     = q_r;
    nq_nxt    = nq_r;
    p_nxt     = p_r;
    head_nxt  = head_r;
    free_nxt  = free_r;
    ov_nxt    = ov_r && !pop;
    ost_nxt   = ost_r;
    oslot_nxt = oslot_r;
    lk_we     = 1'b0;
    lk_wa     = cur_r[IDX_W-1:0];
    lk_wd     = NIL;
    vs_we     = 1'b0;
    vs_wa     = cur_r[IDX_W-1:0];
    unique case (st_r)
      S_IDLE: begin
        if (cmd_valid && !ov_r) begin
          op_nxt   = cmd.op;
          item_nxt = cmd.item;
          key_nxt  = cmd.key;
          prev_nxt = NIL;
          st_nxt   = S_FETCH;
          ost_nxt  = ST_OK;
          oslot_nxt = '0;
          unique case (cmd.op)
            OP_INS_HEAD, OP_INS_TAIL: begin
              cur_nxt = free_r;
              ret_nxt = S_ALLOC;
              if (free_r == NIL) begin
                st_nxt = S_IDLE; ov_nxt = 1'b1; ost_nxt = ST_FULL;
              end
            end
            OP_INS_AFTER, OP_DEL_AFTER: begin
              cur_nxt = head_r;
              ret_nxt = S_SEARCH;
              if (head_r == NIL) begin
                st_nxt = S_IDLE; ov_nxt = 1'b1; ost_nxt = ST_NOTFOUND;
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
              cur_nxt = head_r;
              ret_nxt = (cmd.op == OP_DEL_HEAD) ? S_UNLINK : S_LAST;
              if (head_r == NIL) begin
                st_nxt = S_IDLE; ov_nxt = 1'b1; ost_nxt = ST_EMPTY;
              end
            end
            default: begin
              st_nxt = S_IDLE; ov_nxt = 1'b1; ost_nxt = ST_NOTFOUND;
            end
          endcase
        end
      end
      S_FETCH: begin
        st_nxt = ret_r;
      end
      // take the free-list head as the new node
      S_ALLOC: begin
        p_nxt    = cur_r;
        free_nxt = link_eff;
        vs_we    = 1'b1;
        lk_we    = 1'b1;
        unique case (op_r)
          OP_INS_HEAD: begin
            lk_wd     = head_r;
            head_nxt  = cur_r;
            st_nxt    = S_IDLE;
            ov_nxt    = 1'b1;
            oslot_nxt = cur_r[7:0];
          end
          OP_INS_AFTER: begin
            lk_wd  = nq_r;
            st_nxt = S_LINK;
          end
          default: begin
            lk_wd = NIL;
            if (head_r == NIL) begin
              head_nxt  = cur_r;
              st_nxt    = S_IDLE;
              ov_nxt    = 1'b1;
              oslot_nxt = cur_r[7:0];
            end else begin
              cur_nxt = head_r;
              ret_nxt = S_LAST;
              st_nxt  = S_FETCH;
            end
          end
        endcase
      end
      // walk for the first match
      S_SEARCH: begin
        if (vs_rd_r == key_r) begin
          q_nxt  = cur_r;
          nq_nxt = link_eff;
          if (op_r == OP_INS_AFTER) begin
            if (free_r == NIL) begin
              st_nxt = S_IDLE; ov_nxt = 1'b1; ost_nxt = ST_FULL;
            end else begin
              cur_nxt = free_r; ret_nxt = S_ALLOC; st_nxt = S_FETCH;
            end
          end else if (link_eff == NIL) begin
            st_nxt = S_IDLE; ov_nxt = 1'b1; ost_nxt = ST_NOTFOUND;
          end else begin
            cur_nxt = link_eff; ret_nxt = S_UNLINK; st_nxt = S_FETCH;
          end
        end else if (link_eff == NIL) begin
          st_nxt = S_IDLE; ov_nxt = 1'b1; ost_nxt = ST_NOTFOUND;
        end else begin
          cur_nxt = link_eff; st_nxt = S_FETCH;
        end
      end
      // walk to the last node
      S_LAST: begin
        if (link_eff != NIL) begin
          prev_nxt = cur_r;
          cur_nxt  = link_eff;
          st_nxt   = S_FETCH;
        end else if (op_r == OP_INS_TAIL) begin
          lk_we     = 1'b1;
          lk_wd     = p_r;
          st_nxt    = S_IDLE;
          ov_nxt    = 1'b1;
          oslot_nxt = p_r[7:0];
        end else begin
          p_nxt  = cur_r;
          st_nxt = S_RELEASE;
          if (prev_r == NIL) begin
            head_nxt = NIL;
          end else begin
            lk_we = 1'b1;
            lk_wa = prev_r[IDX_W-1:0];
            lk_wd = NIL;
          end
        end
      end
      // cut the fetched node out of the list
      S_UNLINK: begin
        p_nxt  = cur_r;
        st_nxt = S_RELEASE;
        if (op_r == OP_DEL_HEAD) begin
          head_nxt = link_eff;
        end else begin
          lk_we = 1'b1;
          lk_wa = q_r[IDX_W-1:0];
          lk_wd = link_eff;
        end
      end
      // return the node to the free list
      S_RELEASE: begin
        lk_we     = 1'b1;
        lk_wa     = p_r[IDX_W-1:0];
        lk_wd     = free_r;
        free_nxt  = p_r;
        st_nxt    = S_IDLE;
        ov_nxt    = 1'b1;
        oslot_nxt = p_r[7:0];
      end
      // hook the new node after the match
      S_LINK: begin
        lk_we     = 1'b1;
        lk_wa     = q_r[IDX_W-1:0];
        lk_wd     = p_r;
        st_nxt    = S_IDLE;
        ov_nxt    = 1'b1;
        oslot_nxt = p_r[7:0];
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ret_r  <= S_IDLE;
      head_r <= NIL;
      free_r <= '0;
      ov_r   <= 1'b0;
      vld_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      ret_r  <= ret_nxt;
      head_r <= head_nxt;
      free_r <= free_nxt;
      ov_r   <= ov_nxt;
      if (lk_we) begin
        vld_r[lk_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    item_r  <= item_nxt;
    key_r   <= key_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    q_r     <= q_nxt;
    nq_r    <= nq_nxt;
    p_r     <= p_nxt;
    ost_r   <= ost_nxt;
    oslot_r <= oslot_nxt;
  end

  // link and value memories
  always_ff @(posedge clk) begin
    if (lk_we) begin
      lk_mem[lk_wa] <= lk_wd;
    end
    if (vs_we) begin
      vs_mem[vs_wa] <= item_r;
    end
    lk_rd_r <= lk_mem[cur_r[IDX_W-1:0]];
    vs_rd_r <= vs_mem[cur_r[IDX_W-1:0]];
    lv_rd_r <= vld_r[cur_r[IDX_W-1:0]];
    ra_rd_r <= cur_r[IDX_W-1:0];
  end

  // a failed command reports slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r != ST_OK) |-> (oslot_r == '0))
    else $error("nonzero slot on failed command");

  // while a command runs the result register is empty
  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !ov_r)
    else $error("result pending during command");

  // head and free pointers stay within the store or null
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= NIL) && (free_r <= NIL))
    else $error("pointer out of range");

  // a fetch always hands over to an evaluation state
  a_fetch_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FETCH) |=> (st_r != S_IDLE) && (st_r != S_FETCH))
    else $error("fetch without evaluation");

endmodule

/* design/array_linked_list_engine.sv */
`timescale 1ns / 1ps
// channel  ports                                   handshake
// input    in_kind, in_item, in_match_value        push / full
// result   out_status, out_slot                    empty / pop
//
// head inserts run S_FETCH and S_ALLOC; head deletes run S_FETCH, S_UNLINK
// and S_RELEASE; tail and match commands follow links one node at a time
// through S_FETCH and S_SEARCH or S_LAST (registered link and value memory
// reads); reset is synchronous; the link store reset chain comes from
// per-entry written bits, so no clearing pass is needed and push is taken
// at once; a two-word command queue keeps accepting while a result waits for pop
module array_linked_list_engine
  import alle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_item,
  input  logic [31:0] in_match_value,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slot
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  alle_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_item        (in_item),
    .in_match_value (in_match_value),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take)
  );

  alle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .empty      (empty),
    .pop        (pop),
    .out_status (out_status),
    .out_slot   (out_slot)
  );

endmodule

/* test/array_linked_list_engine_chk.sv */
`timescale 1ns / 1ps
module array_linked_list_engine_chk
  import alle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_item,
  input  logic [31:0] in_match_value,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_slot,
  output int          errors,
  output int          pending,
  output int          words_in,
  output int          cnt_ok,
  output int          cnt_full,
  output int          cnt_empty,
  output int          cnt_notfound
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
  } reply_t;

  // shadow of the node store
  val_t   node_val  [NODES];
  ptr_t   node_link [NODES];
  ptr_t   list_top;
  ptr_t   free_top;
  reply_t replies_due [$];

  assign pending = replies_due.size();

  task automatic report(input string what, input int want, input int got);
    $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  function automatic ptr_t find_key(input val_t key);
    ptr_t q;
    q = list_top;
    for (int n = 0; n < NODES && q < NIL; n++) begin
      if (node_val[q[IDX_W-1:0]] == key) return q;
      q = node_link[q[IDX_W-1:0]];
    end
    return NIL;
  endfunction

  // walk to the last node, also returning its predecessor
  function automatic ptr_t find_last(output ptr_t prev);
    ptr_t cur;
    prev = NIL;
    cur  = list_top;
    for (int n = 0; n < NODES && cur < NIL && node_link[cur[IDX_W-1:0]] < NIL; n++) begin
      prev = cur;
      cur  = node_link[cur[IDX_W-1:0]];
    end
    return cur;
  endfunction

  function automatic reply_t predict(input logic [2:0] kind, input val_t item,
                                     input val_t key);
    reply_t r;
    ptr_t   p, q, prev;
    r.status = ST_OK;
    r.slot   = '0;
    p        = NIL;
    case (kind)
      KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_AFTER: begin
        q = (kind == KIND_INS_AFTER) ? find_key(key) : NIL;
        if (kind == KIND_INS_AFTER && q >= NIL) begin
          r.status = ST_NOTFOUND;
        end else if (free_top >= NIL) begin
          r.status = ST_FULL;
        end else begin
          p        = free_top;
          free_top = node_link[p[IDX_W-1:0]];
          node_val[p[IDX_W-1:0]] = item;
          if (kind == KIND_INS_HEAD) begin
            node_link[p[IDX_W-1:0]] = list_top;
            list_top = p;
          end else if (kind == KIND_INS_AFTER) begin
            node_link[p[IDX_W-1:0]] = node_link[q[IDX_W-1:0]];
            node_link[q[IDX_W-1:0]] = p;
          end else begin
            node_link[p[IDX_W-1:0]] = NIL;
            if (list_top >= NIL) list_top = p;
            else begin
              q = find_last(prev);
              node_link[q[IDX_W-1:0]] = p;
            end
          end
        end
      end
      KIND_DEL_HEAD, KIND_DEL_TAIL: begin
        if (list_top >= NIL) begin
          r.status = ST_EMPTY;
        end else if (kind == KIND_DEL_HEAD) begin
          p        = list_top;
          list_top = node_link[p[IDX_W-1:0]];
        end else begin
          p = find_last(prev);
          if (prev >= NIL) list_top = NIL;
          else node_link[prev[IDX_W-1:0]] = NIL;
        end
      end
      KIND_DEL_AFTER: begin
        q = find_key(key);
        if (q >= NIL || node_link[q[IDX_W-1:0]] >= NIL) begin
          r.status = ST_NOTFOUND;
        end else begin
          p = node_link[q[IDX_W-1:0]];
          node_link[q[IDX_W-1:0]] = node_link[p[IDX_W-1:0]];
        end
      end
      default: r.status = ST_NOTFOUND;
    endcase
    // freed node goes back on the free chain
    if (r.status == ST_OK && (kind == KIND_DEL_HEAD || kind == KIND_DEL_TAIL ||
                              kind == KIND_DEL_AFTER)) begin
      node_link[p[IDX_W-1:0]] = free_top;
      free_top = p;
    end
    if (r.status == ST_OK) r.slot = p[7:0];
    return r;
  endfunction

  // watch both channels
  always @(posedge clk) begin
    reply_t e;
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        node_link[i] = ptr_t'(i + 1);
        node_val[i]  = '0;
      end
      list_top = NIL;
      free_top = '0;
      replies_due.delete();
      errors = 0; words_in = 0;
      cnt_ok = 0; cnt_full = 0; cnt_empty = 0; cnt_notfound = 0;
    end else begin
      if (pop && !empty) begin
        if (replies_due.size() == 0) begin
          report("unexpected word, status", -1, out_status);
        end else begin
          e = replies_due.pop_front();
          if (out_status !== e.status) report("status", e.status, out_status);
          if (out_slot !== e.slot) report("slot", e.slot, out_slot);
          case (e.status)
            ST_OK:    cnt_ok++;
            ST_FULL:  cnt_full++;
            ST_EMPTY: cnt_empty++;
            default:  cnt_notfound++;
          endcase
        end
      end
      if (push && !full) begin
        replies_due.push_back(predict(in_kind, in_item, in_match_value));
        words_in++;
      end
    end
  end

endmodule

/* test/array_linked_list_engine_tb.sv */
`timescale 1ns / 1ps
module array_linked_list_engine_tb;
  import alle_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int         CYCLE_LIMIT  = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_item = '0;
  logic [31:0] in_match_value = '0;
  logic        full, empty;
  logic [1:0]  out_status;
  logic [7:0]  out_slot;
  int          errors, pending, words_in;
  int          cnt_ok, cnt_full, cnt_empty, cnt_notfound;
  int          cycles = 0;
  logic        steady = 1'b0;
  logic [31:0] pool [16];

  always #6 clk = ~clk;

  array_linked_list_engine u_top (
    .clk, .rst_n, .push, .full, .in_kind, .in_item, .in_match_value,
    .empty, .pop, .out_status, .out_slot
  );

  array_linked_list_engine_chk u_chk (
    .clk, .rst_n, .push, .full, .in_kind, .in_item, .in_match_value,
    .empty, .pop, .out_status, .out_slot,
    .errors, .pending, .words_in,
    .cnt_ok, .cnt_full, .cnt_empty, .cnt_notfound
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk) begin
    pop <= steady || ($urandom_range(0, 99) >= 25);
  end

  task automatic send(input logic [2:0] kind, input logic [31:0] item,
                      input logic [31:0] key);
    logic taken;
    while (!steady && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    in_kind        <= kind;
    in_item        <= item;
    in_match_value <= key;
    forever begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
      if (taken) break;
    end
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 70) return pool[$urandom_range(0, 15)];
    return $urandom();
  endfunction

  // random command, insert share given in percent
  task automatic random_word(input int ins_pct);
    logic [2:0] kind;
    int         r;
    r = $urandom_range(0, 99);
    if (r == 0) kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    else if ($urandom_range(0, 99) < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       kind = KIND_INS_HEAD;
        1:       kind = KIND_INS_TAIL;
        default: kind = KIND_INS_AFTER;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       kind = KIND_DEL_HEAD;
        1:       kind = KIND_DEL_TAIL;
        default: kind = KIND_DEL_AFTER;
      endcase
    end
    send(kind, pick_value(), pick_value());
  endtask

  initial begin
    pool[0] = 32'h8000_0000; pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'hFFFF_FFFF; pool[3] = 32'h0000_0000;
    for (int i = 4; i < 16; i++) pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list cases first, then extremes of values
    send(KIND_DEL_HEAD,  32'h0, 32'h0);
    send(KIND_DEL_TAIL,  32'h0, 32'h0);
    send(KIND_DEL_AFTER, 32'h0, 32'h0);
    send(KIND_INS_AFTER, 32'h5, 32'h0);
    send(KIND_INS_HEAD,  32'h8000_0000, 32'h0);
    send(KIND_INS_TAIL,  32'h7FFF_FFFF, 32'h0);
    send(KIND_INS_AFTER, 32'hFFFF_FFFF, 32'h8000_0000);
    send(KIND_INS_AFTER, 32'h0, 32'h1234_5678);
    send(KIND_DEL_AFTER, 32'h0, 32'h7FFF_FFFF);
    send(KIND_DEL_AFTER, 32'h0, 32'hFFFF_FFFF);
    send(KIND_DEL_AFTER, 32'h0, 32'h8000_0000);
    send(KIND_SPARE_A,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(KIND_SPARE_B,   32'h0, 32'h0);
    send(KIND_INS_TAIL,  32'h0, 32'h0);
    send(KIND_DEL_TAIL,  32'h0, 32'h0);
    send(KIND_DEL_TAIL,  32'h0, 32'h0);
    send(KIND_DEL_HEAD,  32'h0, 32'h0);
    send(KIND_INS_HEAD,  32'h5555_5555, 32'h0);
    send(KIND_INS_AFTER, 32'hAAAA_AAAA, 32'h5555_5555);
    send(KIND_DEL_HEAD,  32'h0, 32'h0);

    // fill past capacity, drain past empty, then mixed traffic
    for (int i = 0; i < 900; i++) begin
      steady <= (i >= 400 && i < 550);
      if (i < 350)      random_word(92);
      else if (i < 650) random_word(8);
      else              random_word(50);
    end
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("%0d commands sent: %0d ok, %0d full, %0d empty, %0d not found",
             words_in, cnt_ok, cnt_full, cnt_empty, cnt_notfound);
    $display("list filled to capacity and drained, with random stalls on both sides");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/alle_pkg.sv
design/alle_front.sv
design/alle_back.sv
design/array_linked_list_engine.sv
test/array_linked_list_engine_chk.sv
test/array_linked_list_engine_tb.sv
